>>> src/spatial_grid_binning_table_defines.svh
// Assertion macros for the spatial grid binning table.
`ifndef SPATIAL_GRID_BINNING_TABLE_DEFINES_SVH
`define SPATIAL_GRID_BINNING_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define SGBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SGBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SGBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SGBT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/sgbt_pkg.sv
// Types and constants shared by the spatial grid binning table.
package sgbt_pkg;

    // operation codes on the kind field
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE  = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_UNFILLED = 2'd3;

    // configuration port
    localparam int              APB_AW        = 3;
    localparam logic [APB_AW-3:0] REG_CELL_SIZE = '0;
    localparam logic [7:0]      CELL_SIZE_RST = 8'd16;

    // coordinate divider
    localparam int COORD_W   = 16;
    localparam int CELL_W    = 8;
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_WAIT,
        S_CHECK,
        S_CNT_RD,
        S_CNT_USE,
        S_ENT_RD,
        S_ENT_USE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> src/spatial_grid_binning_table.sv
// Every non-clear request takes two divisions on the one shared divider; one item at a
// time, the next accepted in the cycle after the result is loaded into the output register.
// Clear sweeps the count memory before its result, one count memory word per cycle.
// Reset (i_rst_n low, synchronous) sets cell_size to 16 and starts the same count sweep,
// during which no transaction is accepted; APB writes still land.
`include "spatial_grid_binning_table_defines.svh"

module spatial_grid_binning_table import sgbt_pkg::*; #(
    parameter int GRID_COLS    = 16,
    parameter int GRID_ROWS    = 16,
    parameter int BUCKET_SLOTS = 8,
    parameter int VALUE_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [15:0]       i_x_coord,
    input  logic [15:0]       i_y_coord,
    input  logic [31:0]       i_entry_value,
    input  logic [2:0]        i_slot_index,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [3:0]        o_count,
    output logic [31:0]       o_value_out
);

    localparam int NUM_BUCKETS = GRID_COLS * GRID_ROWS;
    localparam int NUM_ENTRIES = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int BIDX_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int EADDR_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(BUCKET_SLOTS + 1);

    localparam logic [BIDX_W-1:0]  LAST_BUCKET = BIDX_W'(NUM_BUCKETS - 1);
    localparam logic [COORD_W-1:0] COLS_Q      = COORD_W'(GRID_COLS);
    localparam logic [COORD_W-1:0] ROWS_Q      = COORD_W'(GRID_ROWS);
    localparam logic [7:0]         SLOTS_Q     = 8'(BUCKET_SLOTS);

    t_state r_state;
    t_state n_state;

    logic [CELL_W-1:0]     r_cell;
    logic [1:0]            r_kind;
    logic [COORD_W-1:0]    r_x;
    logic [COORD_W-1:0]    r_y;
    logic [VALUE_BITS-1:0] r_val;
    logic [2:0]            r_slot;
    logic [COORD_W-1:0]    r_col;
    logic [COORD_W-1:0]    r_row;
    logic [BIDX_W-1:0]     r_bidx;
    logic [EADDR_W-1:0]    r_eaddr;
    logic [BIDX_W-1:0]     r_sweep;
    logic                  r_clr_op;

    logic [CNT_W-1:0]      cnt_mem [NUM_BUCKETS];
    logic [CNT_W-1:0]      r_cnt_q;
    logic [VALUE_BITS-1:0] ent_mem [NUM_ENTRIES];
    logic [VALUE_BITS-1:0] r_ent_q;

    logic [1:0]            r_res_status;
    logic [3:0]            r_res_count;
    logic [31:0]           r_res_value;

    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [3:0]            r_out_count;
    logic [31:0]           r_out_value;

    // divider hookup
    t_div_ctl              div_ctl;
    t_div_stat             div_stat;
    logic [COORD_W-1:0]    div_dividend;
    logic [COORD_W-1:0]    div_quotient;
    logic [CELL_W-1:0]     side;

    // control strobes from the sequencer
    logic                  in_accept;
    logic                  cfg_write;
    logic                  outside;
    logic                  cnt_full;
    logic                  slot_ok;
    logic                  out_free;
    logic                  cnt_we;
    logic [BIDX_W-1:0]     cnt_waddr;
    logic [CNT_W-1:0]      cnt_wdata;
    logic                  ent_we;
    logic                  res_load;
    logic [1:0]            n_res_status;
    logic [3:0]            n_res_count;
    logic [31:0]           n_res_value;
    logic [BIDX_W-1:0]     bucket_calc;
    logic [EADDR_W-1:0]    ins_addr;
    logic [EADDR_W-1:0]    rd_addr;
    logic [CNT_W-1:0]      cnt_inc;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[APB_AW-1:2] == REG_CELL_SIZE) ? {24'd0, r_cell} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= CELL_SIZE_RST;
        end else if (cfg_write && (paddr[APB_AW-1:2] == REG_CELL_SIZE)) begin
            r_cell <= pwdata[CELL_W-1:0];
        end
    end

    // a zero cell size acts as one
    assign side = (r_cell == '0) ? CELL_W'(1) : r_cell;

    sgbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (side),
        .o_stat     (div_stat),
        .o_quotient (div_quotient)
    );

    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign outside     = (r_col >= COLS_Q) || (r_row >= ROWS_Q);
    assign bucket_calc = BIDX_W'(32'(r_col) * 32'(GRID_ROWS) + 32'(r_row));
    assign cnt_full    = (8'(r_cnt_q) >= SLOTS_Q);
    assign slot_ok     = ({5'd0, r_slot} < 8'(r_cnt_q)) && ({5'd0, r_slot} < SLOTS_Q);
    assign ins_addr    = EADDR_W'(32'(r_bidx) * 32'(BUCKET_SLOTS) + 32'(r_cnt_q));
    assign rd_addr     = EADDR_W'(32'(r_bidx) * 32'(BUCKET_SLOTS) + 32'(r_slot));
    assign cnt_inc     = CNT_W'(r_cnt_q + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        div_ctl      = '0;
        div_dividend = r_x;
        cnt_we       = 1'b0;
        cnt_waddr    = r_bidx;
        cnt_wdata    = '0;
        ent_we       = 1'b0;
        res_load     = 1'b0;
        n_res_status = STATUS_OK;
        n_res_count  = 4'd0;
        n_res_value  = 32'd0;
        unique case (r_state)
            S_SWEEP: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_sweep;
                if (r_sweep == LAST_BUCKET) begin
                    res_load = r_clr_op;
                    n_state  = r_clr_op ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_kind == KIND_CLEAR) ? S_SWEEP : S_DIVX_GO;
                end
            end
            S_DIVX_GO: begin
                div_ctl.start = 1'b1;
                n_state       = S_DIVX_WAIT;
            end
            S_DIVX_WAIT: begin
                if (div_stat.done) begin
                    div_ctl.start = 1'b1;
                    div_dividend  = r_y;
                    n_state       = S_DIVY_WAIT;
                end
            end
            S_DIVY_WAIT: begin
                div_dividend = r_y;
                if (div_stat.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (outside) begin
                    res_load     = 1'b1;
                    n_res_status = STATUS_OUTSIDE;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                n_state = S_CNT_USE;
            end
            S_CNT_USE: begin
                n_res_count = 4'(r_cnt_q);
                priority if (r_kind == KIND_INSERT) begin
                    res_load = 1'b1;
                    n_state  = S_FIN;
                    if (cnt_full) begin
                        n_res_status = STATUS_FULL;
                    end else begin
                        ent_we      = 1'b1;
                        cnt_we      = 1'b1;
                        cnt_wdata   = cnt_inc;
                        n_res_count = 4'(cnt_inc);
                    end
                end else if (r_kind == KIND_COUNT) begin
                    res_load = 1'b1;
                    n_state  = S_FIN;
                end else if (slot_ok) begin
                    n_state = S_ENT_RD;
                end else begin
                    res_load     = 1'b1;
                    n_res_status = STATUS_UNFILLED;
                    n_state      = S_FIN;
                end
            end
            S_ENT_RD: begin
                n_state = S_ENT_USE;
            end
            S_ENT_USE: begin
                res_load    = 1'b1;
                n_res_count = 4'(r_cnt_q);
                n_res_value = 32'(r_ent_q);
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= '0;
            r_clr_op <= 1'b0;
        end else begin
            if (in_accept) begin
                r_sweep  <= '0;
                r_clr_op <= (i_kind == KIND_CLEAR);
            end else if (r_state == S_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind <= i_kind;
            r_x    <= i_x_coord;
            r_y    <= i_y_coord;
            r_val  <= VALUE_BITS'(i_entry_value);
            r_slot <= i_slot_index;
        end
        if ((r_state == S_DIVX_WAIT) && div_stat.done) begin
            r_col <= div_quotient;
        end
        if ((r_state == S_DIVY_WAIT) && div_stat.done) begin
            r_row <= div_quotient;
        end
        if (r_state == S_CHECK) begin
            r_bidx <= bucket_calc;
        end
        if (r_state == S_CNT_USE) begin
            r_eaddr <= rd_addr;
        end
        if (res_load) begin
            r_res_status <= n_res_status;
            r_res_count  <= n_res_count;
            r_res_value  <= n_res_value;
        end
    end

    // bucket count memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= cnt_mem[r_bidx];
    end

    // bucket entry memory
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ins_addr] <= r_val;
        end
        r_ent_q <= ent_mem[r_eaddr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_status <= r_res_status;
            r_out_count  <= r_res_count;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_value_out = r_out_value;

    `SGBT_ASSERT_IMP(a_ready_div_idle, i_clk, i_rst_n, o_in_ready, !div_stat.busy, "input ready while divider busy")
    `SGBT_ASSERT_IMP(a_value_only_ok, i_clk, i_rst_n, o_out_valid && (o_status != STATUS_OK), o_value_out == 32'd0, "nonzero value on a failed result")
    `SGBT_ASSERT_NXT(a_clear_sweeps, i_clk, i_rst_n, in_accept && (i_kind == KIND_CLEAR), (r_state == S_SWEEP) && (r_sweep == '0), "clear did not start the count sweep")

endmodule

>>> src/sgbt_div.sv
// Restoring divider: 16-bit coordinate by 8-bit cell size, one quotient bit per cycle.
module sgbt_div import sgbt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_ctl           i_ctl,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [CELL_W-1:0]  i_divisor,
    output t_div_stat          o_stat,
    output logic [COORD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_quo;
    logic [CELL_W-1:0]    r_rem;
    logic [CELL_W-1:0]    r_div;

    logic [CELL_W:0]      trial;
    logic                 q_bit;
    logic [CELL_W-1:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_quo[COORD_W-1]};
        q_bit = (trial >= {1'b0, r_div});
        // remainder stays below the divisor, so the top bit drops out
        n_rem = q_bit ? CELL_W'(trial - {1'b0, r_div}) : CELL_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[COORD_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule
